>>> rtl/tkemf_pkg.sv
// ----------------------------------------------------------------------------
// tkemf_pkg
// Shared widths, range codes, pipeline tag and inverse polynomial
// coefficients for the type K EMF to temperature converter.
// ----------------------------------------------------------------------------
package tkemf_pkg;

    // field and datapath widths
    localparam int unsigned EMF_W   = 18;
    localparam int unsigned TEMP_W  = 20;
    localparam int unsigned ACC_W   = 48;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned DEGREE  = 9;
    localparam int unsigned DEG_W   = $clog2(DEGREE + 1);

    // constant divider: chunks per division and its latency
    localparam int unsigned CDIV_CHUNKS = 3;
    localparam int unsigned CDIV_LAT    = 2 * CDIV_CHUNKS;

    // range limits in microvolts
    localparam logic signed [EMF_W-1:0] NEG_LIMIT_UV  = -18'sd5891;
    localparam logic signed [EMF_W-1:0] ZERO_UV       = 18'sd0;
    localparam logic signed [EMF_W-1:0] LOW_LIMIT_UV  = 18'sd20644;
    localparam logic signed [EMF_W-1:0] HIGH_LIMIT_UV = 18'sd54886;

    // final scaling: rnd(256 * h / 10^9) = ((|h| + 1953125) >> 1) / 1953125
    localparam int unsigned FIN_ROUND = 1953125;
    localparam int unsigned FIN_DIV   = 1953125;

    // coefficient set codes
    typedef enum logic [1:0] {
        RANGE_NEG  = 2'd0,
        RANGE_LOW  = 2'd1,
        RANGE_HIGH = 2'd2
    } range_t;

    // side information that travels with each item
    typedef struct packed {
        logic                    valid;
        logic                    oor;
        range_t                  rng;
        logic signed [EMF_W-1:0] e;
    } tkemf_tag_t;

    // decimal digits of the divisor when producing degree i from degree i+1
    localparam int unsigned STEP_DIGITS [DEGREE] = '{3, 4, 4, 4, 4, 4, 5, 4, 2};

    // coefficients by degree, scaled to 10^-Q units of that degree
    localparam logic signed [ACC_W-1:0] COEF_NEG [DEGREE+1] = '{
        48'sd0,
        48'sd25173462000,
        -48'sd11662878000,
        -48'sd108336380000,
        -48'sd897735400000,
        -48'sd3734237700000,
        -48'sd8663264300000,
        -48'sd104505980000000,
        -48'sd51920577000000,
        48'sd0
    };

    localparam logic signed [ACC_W-1:0] COEF_LOW [DEGREE+1] = '{
        48'sd0,
        48'sd25083550000,
        48'sd786010600,
        -48'sd25031310000,
        48'sd83152700000,
        -48'sd122803400000,
        48'sd98040360000,
        -48'sd441303000000,
        48'sd105773400000,
        -48'sd105275500
    };

    localparam logic signed [ACC_W-1:0] COEF_HIGH [DEGREE+1] = '{
        -48'sd131805800000,
        48'sd48302220000,
        -48'sd16460310000,
        48'sd5464731000,
        -48'sd965071500,
        48'sd88021930,
        -48'sd3110810,
        48'sd0,
        48'sd0,
        48'sd0
    };

    // coefficient of one degree for one range
    function automatic logic signed [ACC_W-1:0] coef_lookup(input logic [DEG_W-1:0] deg,
                                                            input range_t rng);
        logic signed [ACC_W-1:0] c;
        begin
            case (rng)
                RANGE_NEG:  c = COEF_NEG[deg];
                RANGE_LOW:  c = COEF_LOW[deg];
                RANGE_HIGH: c = COEF_HIGH[deg];
                default:    c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

>>> rtl/tkemf_cdiv.sv
// ----------------------------------------------------------------------------
// tkemf_cdiv
// Pipelined division of an unsigned value by a constant. The dividend is
// taken in chunks from the top; each chunk uses a reciprocal estimate in one
// stage and a remainder fix-up in the next.
// ----------------------------------------------------------------------------
module tkemf_cdiv
    import tkemf_pkg::*;
#(
    parameter int unsigned DIV  = 3125,
    parameter int unsigned IN_W = 59
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [IN_W-1:0] num,
    output logic [IN_W-1:0] quo
);

    localparam int unsigned CW    = (IN_W + CDIV_CHUNKS - 1) / CDIV_CHUNKS;
    localparam int unsigned PAD_W = CW * CDIV_CHUNKS;
    localparam int unsigned RW    = $clog2(DIV);
    localparam int unsigned XW    = RW + CW;
    localparam int unsigned MW    = CW + 1;
    localparam int unsigned LAST  = CDIV_CHUNKS - 1;

    // floor(2^XW / DIV): estimate is exact or one short
    localparam logic [MW-1:0] RECIP = MW'((longint'(1) << XW) / longint'(DIV));
    localparam logic [XW-1:0] DIV_X = XW'(DIV);

    // estimate stage registers
    logic [PAD_W-1:0] a_num_reg [LAST];
    logic [PAD_W-1:0] a_quo_reg [CDIV_CHUNKS];
    logic [XW-1:0]    a_x_reg   [CDIV_CHUNKS];
    logic [CW-1:0]    a_q0_reg  [CDIV_CHUNKS];

    // fix-up stage registers
    logic [PAD_W-1:0] b_num_reg [LAST];
    logic [RW-1:0]    b_rem_reg [LAST];
    logic [PAD_W-1:0] b_quo_reg [CDIV_CHUNKS];

    for (genvar k = 0; k < CDIV_CHUNKS; k++) begin : g_chunk
        logic [PAD_W-1:0]    num_in;
        logic [PAD_W-1:0]    quo_in;
        logic [RW-1:0]       rem_in;
        logic [XW-1:0]       x_next;
        logic [XW+MW-1:0]    prod;
        logic [XW-1:0]       r0;
        logic [CW-1:0]       q_next;
        logic [RW-1:0]       rem_next;
        logic [PAD_W-1:0]    quo_next;

        if (k == 0) begin : g_first
            assign num_in = PAD_W'(num);
            assign quo_in = '0;
            assign rem_in = '0;
        end
        else begin : g_rest
            assign num_in = b_num_reg[k-1];
            assign quo_in = b_quo_reg[k-1];
            assign rem_in = b_rem_reg[k-1];
        end

        // partial dividend and reciprocal estimate
        always_comb
        begin
            x_next = {rem_in, num_in[PAD_W-1-k*CW -: CW]};
            prod   = x_next * RECIP;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_quo_reg[k] <= quo_in;
                a_x_reg[k]   <= x_next;
                a_q0_reg[k]  <= prod[XW +: CW];
            end
        end

        // remainder and one-step correction
        always_comb
        begin
            r0       = a_x_reg[k] - XW'(a_q0_reg[k]) * DIV_X;
            quo_next = a_quo_reg[k];
            if (r0 >= DIV_X)
            begin
                q_next   = a_q0_reg[k] + 1'b1;
                rem_next = RW'(r0 - DIV_X);
            end
            else
            begin
                q_next   = a_q0_reg[k];
                rem_next = RW'(r0);
            end
            quo_next[PAD_W-1-k*CW -: CW] = q_next;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                b_quo_reg[k] <= quo_next;
            end
        end

        // remaining dividend and remainder carried to the next chunk
        if (k < LAST) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_num_reg[k] <= num_in;
                    b_num_reg[k] <= a_num_reg[k];
                    b_rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign quo = b_quo_reg[LAST][IN_W-1:0];

endmodule

>>> rtl/tkemf_step.sv
// ----------------------------------------------------------------------------
// tkemf_step
// One Horner step: h_i = c_i + rnd(h_(i+1) * e / 10^k), rounded half away
// from zero, over ten pipeline stages.
// ----------------------------------------------------------------------------
module tkemf_step
    import tkemf_pkg::*;
#(
    parameter int unsigned DEG = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  tkemf_tag_t              in_tag,
    input  logic signed [ACC_W-1:0] in_acc,
    output tkemf_tag_t              out_tag,
    output logic signed [ACC_W-1:0] out_acc
);

    localparam int unsigned DIGITS = STEP_DIGITS[DEG];
    localparam int unsigned DIV5   = 5 ** DIGITS;
    localparam int unsigned HALF   = (10 ** DIGITS) / 2;
    localparam int unsigned VW     = PROD_W - DIGITS;
    localparam int unsigned HW     = ACC_W / 2;
    localparam int unsigned PPW    = HW + EMF_W;

    // magnitude stage
    tkemf_tag_t       a_tag_reg;
    logic [ACC_W-1:0] a_mag_reg;
    logic [EMF_W-1:0] a_emag_reg;
    logic             a_neg_reg;
    logic [ACC_W-1:0] a_mag_next;
    logic [EMF_W-1:0] a_emag_next;

    // partial product stage
    tkemf_tag_t       b_tag_reg;
    logic [PPW-1:0]   b_hi_reg;
    logic [PPW-1:0]   b_lo_reg;
    logic             b_neg_reg;

    // sum and rounding offset stage
    tkemf_tag_t       c_tag_reg;
    logic [VW-1:0]    c_v_reg;
    logic             c_neg_reg;
    logic [PROD_W-1:0] c_sum_next;

    // tag alignment with the divider
    tkemf_tag_t       dl_tag_reg [CDIV_LAT];
    logic             dl_neg_reg [CDIV_LAT];
    logic [VW-1:0]    div_quo;

    // coefficient add stage
    tkemf_tag_t              d_tag_reg;
    logic signed [ACC_W-1:0] d_acc_reg;
    logic signed [ACC_W-1:0] d_acc_next;
    logic signed [ACC_W-1:0] d_coef;
    logic signed [ACC_W-1:0] d_q;

    // magnitudes of accumulator and emf
    always_comb
    begin
        a_mag_next  = in_acc[ACC_W-1] ? ACC_W'(-in_acc) : ACC_W'(in_acc);
        a_emag_next = in_tag.e[EMF_W-1] ? EMF_W'(-in_tag.e) : EMF_W'(in_tag.e);
    end

    // product plus half divisor, decimal factor 2^k dropped by the shift
    always_comb
    begin
        c_sum_next = PROD_W'({b_hi_reg, {HW{1'b0}}}) + PROD_W'(b_lo_reg)
                   + PROD_W'(HALF);
    end

    // remaining 5^k factor
    tkemf_cdiv #(
        .DIV  (DIV5),
        .IN_W (VW)
    ) u_cdiv (
        .clk (clk),
        .en  (en),
        .num (c_v_reg),
        .quo (div_quo)
    );

    // signed quotient onto the coefficient
    always_comb
    begin
        d_coef = coef_lookup(DEG_W'(DEG), dl_tag_reg[CDIV_LAT-1].rng);
        d_q    = ACC_W'(div_quo);
        if (dl_neg_reg[CDIV_LAT-1])
        begin
            d_acc_next = d_coef - d_q;
        end
        else
        begin
            d_acc_next = d_coef + d_q;
        end
    end

    // tag pipeline, valid bits cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
            c_tag_reg <= '0;
            for (int i = 0; i < CDIV_LAT; i++)
            begin
                dl_tag_reg[i] <= '0;
            end
            d_tag_reg <= '0;
        end
        else if (en)
        begin
            a_tag_reg     <= in_tag;
            b_tag_reg     <= a_tag_reg;
            c_tag_reg     <= b_tag_reg;
            dl_tag_reg[0] <= c_tag_reg;
            for (int i = 1; i < CDIV_LAT; i++)
            begin
                dl_tag_reg[i] <= dl_tag_reg[i-1];
            end
            d_tag_reg <= dl_tag_reg[CDIV_LAT-1];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg     <= a_mag_next;
            a_emag_reg    <= a_emag_next;
            a_neg_reg     <= in_acc[ACC_W-1] ^ in_tag.e[EMF_W-1];
            b_hi_reg      <= a_mag_reg[ACC_W-1:HW] * a_emag_reg;
            b_lo_reg      <= a_mag_reg[HW-1:0] * a_emag_reg;
            b_neg_reg     <= a_neg_reg;
            c_v_reg       <= c_sum_next[PROD_W-1:DIGITS];
            c_neg_reg     <= b_neg_reg;
            dl_neg_reg[0] <= c_neg_reg;
            for (int i = 1; i < CDIV_LAT; i++)
            begin
                dl_neg_reg[i] <= dl_neg_reg[i-1];
            end
            d_acc_reg <= d_acc_next;
        end
    end

    assign out_tag = d_tag_reg;
    assign out_acc = d_acc_reg;

endmodule

>>> rtl/thermocouple_k_emf_to_temp_core.sv
// ----------------------------------------------------------------------------
// thermocouple_k_emf_to_temp_core: type K EMF to temperature, inverse polynomial
// Pipeline from input transfer to result: input stage, nine Horner
// steps of ten stages each, then eight stages of final scaling and output.
// Throughput one item per clock; a stalled output freezes the whole pipeline,
// while an empty input stage still takes a transfer.
// Reset clears the tags, valid bits included; datapath registers are not reset.
// ----------------------------------------------------------------------------
module thermocouple_k_emf_to_temp_core
    import tkemf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] emf_uv
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] temp_q8
    output logic [2:0]  m_tuser    // [1:0] range_index, [2] out_of_range
);

    logic adv;
    logic in_load;

    // input stage
    tkemf_tag_t              i_tag_reg;
    tkemf_tag_t              i_tag_next;
    logic signed [ACC_W-1:0] i_acc_reg;
    logic signed [EMF_W-1:0] emf;

    // horner chain
    tkemf_tag_t              chain_tag [DEGREE+1];
    logic signed [ACC_W-1:0] chain_acc [DEGREE+1];

    // final scaling
    tkemf_tag_t              f_tag_reg;
    logic                    f_neg_reg;
    logic [ACC_W-1:0]        f_v_reg;
    logic signed [ACC_W:0]   f_hx;
    logic signed [ACC_W:0]   f_sum_next;
    tkemf_tag_t              fd_tag_reg [CDIV_LAT];
    logic                    fd_neg_reg [CDIV_LAT];
    logic [ACC_W-1:0]        fin_quo;

    // output register
    logic                    out_valid_reg;
    logic [TEMP_W-1:0]       out_temp_reg;
    logic [TEMP_W-1:0]       out_temp_next;
    range_t                  out_rng_reg;
    logic                    out_oor_reg;

    // pipeline moves when the output slot is free or being taken
    assign adv      = m_tready || !out_valid_reg;
    assign in_load  = adv || !i_tag_reg.valid;
    assign s_tready = in_load;

    // range decode of the incoming emf
    always_comb
    begin
        emf              = signed'(s_tdata[EMF_W-1:0]);
        i_tag_next.valid = s_tvalid;
        i_tag_next.e     = emf;
        i_tag_next.oor   = (emf < NEG_LIMIT_UV) || (emf > HIGH_LIMIT_UV);
        if (emf <= ZERO_UV)
        begin
            i_tag_next.rng = RANGE_NEG;
        end
        else if (emf <= LOW_LIMIT_UV)
        begin
            i_tag_next.rng = RANGE_LOW;
        end
        else
        begin
            i_tag_next.rng = RANGE_HIGH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_tag_reg <= '0;
        end
        else if (in_load)
        begin
            i_tag_reg <= i_tag_next;
        end
    end

    // top coefficient starts the accumulator
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            i_acc_reg <= coef_lookup(DEG_W'(DEGREE), i_tag_next.rng);
        end
    end

    assign chain_tag[0] = i_tag_reg;
    assign chain_acc[0] = i_acc_reg;

    // horner steps from degree 8 down to degree 0
    for (genvar g = 0; g < DEGREE; g++) begin : g_step
        tkemf_step #(
            .DEG (DEGREE - 1 - g)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_tag  (chain_tag[g]),
            .in_acc  (chain_acc[g]),
            .out_tag (chain_tag[g+1]),
            .out_acc (chain_acc[g+1])
        );
    end

    // magnitude plus rounding offset, halved
    always_comb
    begin
        f_hx = {chain_acc[DEGREE][ACC_W-1], chain_acc[DEGREE]};
        if (chain_acc[DEGREE][ACC_W-1])
        begin
            f_sum_next = (ACC_W+1)'(FIN_ROUND) - f_hx;
        end
        else
        begin
            f_sum_next = f_hx + (ACC_W+1)'(FIN_ROUND);
        end
    end

    tkemf_cdiv #(
        .DIV  (FIN_DIV),
        .IN_W (ACC_W)
    ) u_fin_cdiv (
        .clk (clk),
        .en  (adv),
        .num (f_v_reg),
        .quo (fin_quo)
    );

    // signed result, forced to zero outside all ranges
    always_comb
    begin
        if (fd_tag_reg[CDIV_LAT-1].oor)
        begin
            out_temp_next = '0;
        end
        else if (fd_neg_reg[CDIV_LAT-1])
        begin
            out_temp_next = TEMP_W'(-fin_quo);
        end
        else
        begin
            out_temp_next = TEMP_W'(fin_quo);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_tag_reg <= '0;
            for (int i = 0; i < CDIV_LAT; i++)
            begin
                fd_tag_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_tag_reg     <= chain_tag[DEGREE];
            fd_tag_reg[0] <= f_tag_reg;
            for (int i = 1; i < CDIV_LAT; i++)
            begin
                fd_tag_reg[i] <= fd_tag_reg[i-1];
            end
            out_valid_reg <= fd_tag_reg[CDIV_LAT-1].valid;
        end
    end

    // final datapath and output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_neg_reg     <= chain_acc[DEGREE][ACC_W-1];
            f_v_reg       <= f_sum_next[ACC_W:1];
            fd_neg_reg[0] <= f_neg_reg;
            for (int i = 1; i < CDIV_LAT; i++)
            begin
                fd_neg_reg[i] <= fd_neg_reg[i-1];
            end
            out_temp_reg <= out_temp_next;
            out_rng_reg  <= fd_tag_reg[CDIV_LAT-1].oor ? RANGE_NEG
                                                       : fd_tag_reg[CDIV_LAT-1].rng;
            out_oor_reg  <= fd_tag_reg[CDIV_LAT-1].oor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-TEMP_W){1'b0}}, out_temp_reg};
    assign m_tuser  = {out_oor_reg, out_rng_reg};

    // out of range gives zero temperature and the first range code
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |->
            (m_tdata[TEMP_W-1:0] == '0 && m_tuser[1:0] == RANGE_NEG))
        else $error("out of range result not cleared");

    // negative range never yields a temperature above zero
    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == RANGE_NEG) |->
            (m_tdata[TEMP_W-1] || m_tdata[TEMP_W-1:0] == '0))
        else $error("positive temperature from negative range");

    // positive ranges always yield a temperature above zero
    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] == RANGE_LOW || m_tuser[1:0] == RANGE_HIGH)) |->
            (!m_tdata[TEMP_W-1] && m_tdata[TEMP_W-1:0] != '0))
        else $error("non-positive temperature from positive range");

endmodule
